// File: design/icw_pkg.sv
// Shared constants and types for the intensity weighted centroid block.
// Used by icw_div and intensity_weighted_centroid; no dependencies.
package icw_pkg;

    localparam int MAX_DIM_DEFAULT    = 1024;
    localparam int PIXEL_BITS_DEFAULT = 16;

    localparam int PIX_PORT_W = 16;
    localparam int DIM_W      = 11;
    localparam int CENT_W     = 19;
    localparam int FRAC_BITS  = 8;
    localparam int ADDR_W     = 1;

    localparam logic [DIM_W-1:0]  DIM_RESET        = 11'd1024;
    localparam logic [ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd0;
    localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_START_X,
        ST_DIV_X,
        ST_START_Y,
        ST_DIV_Y,
        ST_FINISH
    } icw_state_t;

endpackage

// File: design/intensity_weighted_centroid.sv
// Intensity weighted centroid of a pixel frame: top level.
// Depends on icw_pkg and icw_div.
//
// Pixels enter on the s_axis channel, column-major with the row index running
// fastest, one request per cycle while the block accumulates. The frame size
// comes from frame_height (index 0) and frame_width (index 1) on the cfg port;
// write them only between frames. Each frame's last pixel starts the divider,
// which produces the x centroid and then the y centroid, one quotient bit per
// cycle, and then registers the result on m_axis. s_axis_tready is low from the
// frame end until that result is loaded into the output register, which also
// waits for an earlier result still held on m_axis.
// A zero intensity sum skips the divider and reports zero_total on tuser.
// A result waiting on a stalled receiver does not stop the next frame from
// accumulating; only the next frame end waits for it to be taken.
// Reset (synchronous, active low) clears the position counters, the sums and
// the output valid, and sets both dimensions to 1024.
module intensity_weighted_centroid
    import icw_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEFAULT,
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [ADDR_W-1:0]     cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_PORT_W-1:0] s_axis_tdata,   // [15:0] pixel_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [18:0] centroid_x, [37:19] centroid_y
    output logic                  m_axis_tuser    // [0] zero_total
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int SUM_W  = PIXEL_BITS + 2 * CW;
    localparam int WSUM_W = PIXEL_BITS + 3 * CW;
    localparam int NUM_W  = WSUM_W + FRAC_BITS;
    localparam int QUO_W  = CW + 1 + FRAC_BITS;
    localparam logic [CW-1:0] LAST_MAX = CW'(MAX_DIM - 1);

    icw_state_t state_reg, state_next;

    logic [DIM_W-1:0]  height_reg, height_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [CW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [SUM_W-1:0]  isum_reg, isum_next;
    logic [WSUM_W-1:0] cwsum_reg, cwsum_next;
    logic [WSUM_W-1:0] rwsum_reg, rwsum_next;
    logic              zero_reg, zero_next;
    logic [QUO_W-1:0]  qx_reg, qx_next;
    logic              mvalid_reg, mvalid_next;
    logic [CENT_W-1:0] cx_reg, cx_next;
    logic [CENT_W-1:0] cy_reg, cy_next;
    logic              zt_reg, zt_next;

    logic [CW-1:0]           h_last, w_last;
    logic [PIXEL_BITS-1:0]   pix;
    logic [CW:0]             row_wt, col_wt;
    logic [PIXEL_BITS+CW:0]  row_prod, col_prod;
    logic                    accept;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        div_num;
    logic [QUO_W-1:0]        div_quo;

    always_comb begin
        if (height_reg == '0) begin
            h_last = '0;
        end else if (32'(height_reg) > MAX_DIM) begin
            h_last = LAST_MAX;
        end else begin
            h_last = CW'(height_reg - 1'b1);
        end
        if (width_reg == '0) begin
            w_last = '0;
        end else if (32'(width_reg) > MAX_DIM) begin
            w_last = LAST_MAX;
        end else begin
            w_last = CW'(width_reg - 1'b1);
        end
    end

    assign pix      = s_axis_tdata[PIXEL_BITS-1:0];
    assign row_wt   = {1'b0, row_reg} + 1'b1;
    assign col_wt   = {1'b0, col_reg} + 1'b1;
    assign row_prod = pix * row_wt;
    assign col_prod = pix * col_wt;
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_ACCUM);
    assign div_num = (state_reg == ST_START_Y) ? {rwsum_reg, FRAC_BITS'(0)}
                                               : {cwsum_reg, FRAC_BITS'(0)};

    icw_div #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W),
        .QUO_W (QUO_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (isum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next  = state_reg;
        height_next = height_reg;
        width_next  = width_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        isum_next   = isum_reg;
        cwsum_next  = cwsum_reg;
        rwsum_next  = rwsum_reg;
        zero_next   = zero_reg;
        qx_next     = qx_reg;
        mvalid_next = mvalid_reg && !m_axis_tready;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        zt_next     = zt_reg;
        div_start   = 1'b0;

        if (cfg_we) begin
            case (cfg_addr)
                REG_FRAME_HEIGHT: height_next = cfg_wdata;
                REG_FRAME_WIDTH:  width_next  = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_ACCUM: begin
                if (accept) begin
                    isum_next  = isum_reg + SUM_W'(pix);
                    cwsum_next = cwsum_reg + WSUM_W'(col_prod);
                    rwsum_next = rwsum_reg + WSUM_W'(row_prod);
                    if (row_reg >= h_last) begin
                        row_next = '0;
                        if (col_reg >= w_last) begin
                            col_next   = '0;
                            state_next = ST_START_X;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_START_X: begin
                if (isum_reg == '0) begin
                    zero_next  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    zero_next  = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    qx_next    = div_quo;
                    state_next = ST_START_Y;
                end
            end
            ST_START_Y: begin
                div_start  = 1'b1;
                state_next = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!mvalid_reg || m_axis_tready) begin
                    mvalid_next = 1'b1;
                    zt_next     = zero_reg;
                    cx_next     = zero_reg ? '0 : CENT_W'(qx_reg);
                    cy_next     = zero_reg ? '0 : CENT_W'(div_quo);
                    isum_next   = '0;
                    cwsum_next  = '0;
                    rwsum_next  = '0;
                    state_next  = ST_ACCUM;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACCUM;
            height_reg <= DIM_RESET;
            width_reg  <= DIM_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            isum_reg   <= '0;
            cwsum_reg  <= '0;
            rwsum_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            isum_reg   <= isum_next;
            cwsum_reg  <= cwsum_next;
            rwsum_reg  <= rwsum_next;
            mvalid_reg <= mvalid_next;
        end
        zero_reg <= zero_next;
        qx_reg   <= qx_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        zt_reg   <= zt_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {2'b00, cy_reg, cx_reg};
    assign m_axis_tuser  = zt_reg;

endmodule

// File: design/icw_div.sv
// Restoring divider, one quotient bit per cycle, shared by both centroid axes.
// Depends on icw_pkg only through the import convention of the project.
module icw_div
    import icw_pkg::*;
#(
    parameter int NUM_W = 54,
    parameter int DEN_W = 36,
    parameter int QUO_W = 19
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] sh_reg, sh_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial = {rem_reg, sh_reg[QUO_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = ~diff[DEN_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DEN_W'(dividend[NUM_W-1:QUO_W]);
            sh_next   = dividend[QUO_W-1:0];
        end else if (busy_reg) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_next  = {sh_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

endmodule

// File: tb/tb_intensity_weighted_centroid.sv
// Self-checking testbench for intensity_weighted_centroid: streams pixel frames of many
// sizes and fill patterns, predicts each frame's centroid and checks every result.
// Depends on icw_pkg and the intensity_weighted_centroid RTL.
`timescale 1ns / 1ps

module tb_intensity_weighted_centroid;
    import icw_pkg::*;

    localparam int  DRAIN_CYCLES     = 64;
    localparam int  SINK_HOLD_CYCLES = 300;
    localparam int  RANDOM_PIXELS    = 680;
    localparam longint CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [CENT_W-1:0] cx;
        logic [CENT_W-1:0] cy;
        logic              zero;
    } centroid_t;

    typedef enum int {FILL_RANDOM, FILL_SPARSE, FILL_ZERO, FILL_FULL, FILL_DIM} fill_t;

    class centroid_tracker;
        logic [DIM_W-1:0] height_reg;
        logic [DIM_W-1:0] width_reg;
        int unsigned      row_pos;
        int unsigned      col_pos;
        logic [63:0]      total;
        logic [63:0]      col_moment;
        logic [63:0]      row_moment;
        centroid_t        pending[$];
        int               mismatches;
        int               pixels_seen;
        int               frames_checked;
        int               zero_frames;

        function new();
            height_reg = DIM_RESET;
            width_reg  = DIM_RESET;
            row_pos = 0;
            col_pos = 0;
            total = '0;
            col_moment = '0;
            row_moment = '0;
            mismatches = 0;
            pixels_seen = 0;
            frames_checked = 0;
            zero_frames = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_DIM_DEFAULT)
                return MAX_DIM_DEFAULT;
            return {{(32-DIM_W){1'b0}}, v};
        endfunction

        function int unsigned frame_pixels();
            return clamp_dim(height_reg) * clamp_dim(width_reg);
        endfunction

        function void write_dim(logic [ADDR_W-1:0] idx, logic [DIM_W-1:0] val);
            if (idx == REG_FRAME_HEIGHT)
                height_reg = val;
            else if (idx == REG_FRAME_WIDTH)
                width_reg = val;
        endfunction

        function void accumulate_pixel(logic [PIX_PORT_W-1:0] pix);
            int unsigned h;
            int unsigned w;
            logic [63:0] wide_pix;
            logic [63:0] quotient;
            bit          frame_done;
            centroid_t   res;
            h = clamp_dim(height_reg);
            w = clamp_dim(width_reg);
            wide_pix = {48'b0, pix};
            frame_done = 0;
            pixels_seen++;
            if (row_pos > MAX_DIM_DEFAULT)
                row_pos = 0;
            if (col_pos > MAX_DIM_DEFAULT)
                col_pos = 0;
            total      += wide_pix;
            col_moment += wide_pix * 64'(col_pos + 1);
            row_moment += wide_pix * 64'(row_pos + 1);
            if (row_pos >= h - 1) begin
                row_pos = 0;
                if (col_pos >= w - 1)
                    frame_done = 1;
                else
                    col_pos++;
            end else begin
                row_pos++;
            end
            if (!frame_done)
                return;
            if (total == 0) begin
                res = '{cx: '0, cy: '0, zero: 1'b1};
            end else begin
                quotient = (col_moment << FRAC_BITS) / total;
                res.cx = quotient[CENT_W-1:0];
                quotient = (row_moment << FRAC_BITS) / total;
                res.cy = quotient[CENT_W-1:0];
                res.zero = 1'b0;
            end
            pending.push_back(res);
            row_pos = 0;
            col_pos = 0;
            total = '0;
            col_moment = '0;
            row_moment = '0;
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            if (mismatches < 100)
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what,
                         got, want);
            mismatches++;
        endtask

        task check_centroid(logic [39:0] data, logic zflag);
            centroid_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with none outstanding", data, 0);
                return;
            end
            want = pending.pop_front();
            frames_checked++;
            if (want.zero)
                zero_frames++;
            if (data[CENT_W-1:0] !== want.cx)
                report_mismatch("centroid_x", data[CENT_W-1:0], want.cx);
            if (data[2*CENT_W-1:CENT_W] !== want.cy)
                report_mismatch("centroid_y", data[2*CENT_W-1:CENT_W], want.cy);
            if (zflag !== want.zero)
                report_mismatch("zero_total", zflag, want.zero);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [ADDR_W-1:0]     cfg_addr;
    logic [DIM_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_PORT_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tuser;

    centroid_tracker tracker;
    bit              src_throttled;
    bit              sink_throttled;
    bit              sink_hold_request;
    int              sizes_tried;
    longint          cycle_count;

    intensity_weighted_centroid dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap(bit throttled);
        int r;
        if (!throttled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_pixel(input logic [PIX_PORT_W-1:0] pix);
        int gap;
        gap = pick_gap(src_throttled);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= PIX_PORT_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.accumulate_pixel(pix);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_frame(input fill_t fill);
        int unsigned n;
        logic [PIX_PORT_W-1:0] pix;
        n = tracker.frame_pixels();
        for (int unsigned i = 0; i < n; i++) begin
            case (fill)
                FILL_RANDOM: pix = PIX_PORT_W'($urandom);
                FILL_SPARSE: pix = ($urandom_range(0, 9) == 0) ? PIX_PORT_W'($urandom) : '0;
                FILL_ZERO:   pix = '0;
                FILL_FULL:   pix = '1;
                default:     pix = PIX_PORT_W'($urandom_range(0, 3));
            endcase
            send_pixel(pix);
        end
    endtask

    task automatic wait_results();
        while (tracker.pending.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        tracker.write_dim(idx, val);
    endtask

    // Reconfigure only once the block has gone quiet.
    task automatic set_frame(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w);
        end_burst();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FRAME_WIDTH, w);
        sizes_tried++;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r < 7)
            return DIM_W'($urandom_range(1, 6));
        return DIM_W'($urandom_range(7, 16));
    endfunction

    function automatic fill_t pick_fill();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return FILL_RANDOM;
        if (r < 7)
            return FILL_SPARSE;
        if (r == 7)
            return FILL_ZERO;
        if (r == 8)
            return FILL_FULL;
        return FILL_DIM;
    endfunction

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_request) begin
                sink_hold_request = 0;
                stall_left = SINK_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(sink_throttled);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_centroid(m_axis_tdata, m_axis_tuser);
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("** intensity_weighted_centroid: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int random_pixels;
        int nframes;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        src_throttled = 0;
        sink_throttled = 0;
        sink_hold_request = 0;
        sizes_tried = 0;
        random_pixels = 0;
        tracker = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // 1x1 and 0x0 frames: zero total, extremes, alternating bits; then 2x3 frames
        set_frame(1, 1);
        send_pixel('0);
        send_pixel('1);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        send_pixel(16'h0001);
        set_frame(0, 0);
        send_pixel(16'h8000);
        send_pixel('0);
        set_frame(2, 3);
        send_frame(FILL_ZERO);
        send_frame(FILL_FULL);
        for (int i = 0; i < 5; i++)
            send_pixel('0);
        send_pixel(16'h1234);

        // hold the result side long enough for the input to back up
        set_frame(1, 2);
        sink_hold_request = 1;
        for (int i = 0; i < 20; i++)
            send_frame(FILL_RANDOM);
        end_burst();
        wait_results();

        while (random_pixels < RANDOM_PIXELS) begin
            set_frame(pick_dim(), pick_dim());
            src_throttled  = ($urandom_range(0, 3) != 0);
            sink_throttled = ($urandom_range(0, 3) != 0);
            nframes = $urandom_range(1, 6);
            for (int f = 0; f < nframes; f++) begin
                send_frame(pick_fill());
                random_pixels += tracker.frame_pixels();
                if ($urandom_range(0, 9) == 0) begin
                    end_burst();
                    wait_results();
                end
            end
        end

        end_burst();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d pixels in %0d frames (%0d of zero intensity) over %0d sizes",
                 tracker.pixels_seen, tracker.frames_checked, tracker.zero_frames,
                 sizes_tried);
        $display("mismatches: %0d", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("** intensity_weighted_centroid: PASSED **");
        else
            $display("** intensity_weighted_centroid: FAILED **");
        $finish;
    end

endmodule
